@@ rtl/lrip_pkg.sv @@
// ----------------------------------------------------------------------------
// lrip_pkg: shared types and constants
// Item format, opcode, item kind and status codes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lrip_pkg;

  localparam int DATA_W = 20;
  localparam int ANG_W  = 34;

  localparam logic OPC_PROJECT = 1'b0;
  localparam logic OPC_READ    = 1'b1;

  localparam logic [1:0] KIND_PROJECT   = 2'd0;
  localparam logic [1:0] KIND_READ      = 2'd1;
  localparam logic [1:0] KIND_READ_VOID = 2'd2;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_FARTHER = 2'd1;
  localparam logic [1:0] ST_NEAR    = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  localparam logic [1:0] CFG_ROWS      = 2'd0;
  localparam logic [1:0] CFG_COLS      = 2'd1;
  localparam logic [1:0] CFG_MIN_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [5:0]         row;
    logic [9:0]         col;
  } lrip_item_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/lrip_front.sv @@
// ----------------------------------------------------------------------------
// lrip_front: command intake
// Registers each accepted command and tags it as projection, read or void read.
// ----------------------------------------------------------------------------
module lrip_front import lrip_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic               opcode,
  input  logic signed [19:0] point_x,
  input  logic signed [19:0] point_y,
  input  logic signed [19:0] point_z,
  input  logic [5:0]         read_row,
  input  logic [9:0]         read_col,
  output logic               push,
  output lrip_item_t         item
);

  logic       valid_r;
  lrip_item_t item_r;
  lrip_item_t item_nxt;

  // classify the command
  always_comb begin
    item_nxt.x   = point_x;
    item_nxt.y   = point_y;
    item_nxt.z   = point_z;
    item_nxt.row = read_row;
    item_nxt.col = read_col;
    if (opcode == OPC_PROJECT) begin
      item_nxt.kind = KIND_PROJECT;
    end else if ((32'(read_row) < 32'(MAX_ROWS)) && (32'(read_col) < 32'(MAX_COLS))) begin
      item_nxt.kind = KIND_READ;
    end else begin
      item_nxt.kind = KIND_READ_VOID;
    end
  end

  // hold one transfer until it moves into the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign push = valid_r;
  assign item = item_r;

endmodule

@@ rtl/lrip_queue.sv @@
// ----------------------------------------------------------------------------
// lrip_queue: command queue
// Four-entry FIFO between intake and the processing engine.
// ----------------------------------------------------------------------------
module lrip_queue import lrip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lrip_item_t push_item,
  input  logic       pop,
  output lrip_item_t head,
  output logic       not_empty,
  output logic [2:0] count
);

  lrip_item_t mem_r [4];
  logic [1:0] wptr_r;
  logic [1:0] rptr_r;
  logic [2:0] count_r;
  logic [2:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 3'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 3'd1;
    end
  end

  // advance pointers and store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 2'd0;
      rptr_r  <= 2'd0;
      count_r <= 3'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= wptr_r + 2'd1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 2'd1;
      end
    end
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  assign head      = mem_r[rptr_r];
  assign not_empty = (count_r != 3'd0);
  assign count     = count_r;

endmodule

@@ rtl/lrip_back.sv @@
// ----------------------------------------------------------------------------
// lrip_back: processing engine
// Root sums, bit-serial square roots, iterative CORDIC, pixel mapping and the
// range store with its nearest-range update and read-and-clear.
// ----------------------------------------------------------------------------
module lrip_back import lrip_pkg::*; #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        image_rows,
  input  logic [10:0]       image_cols,
  input  logic [19:0]       min_range,
  input  logic              q_not_empty,
  input  lrip_item_t        q_head,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [5:0]        out_pixel_row,
  output logic [9:0]        out_pixel_col,
  output logic [19:0]       out_range_value
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_CORD = 4'd6;
  localparam logic [3:0] S_MAP1 = 4'd7;
  localparam logic [3:0] S_MAP2 = 4'd8;
  localparam logic [3:0] S_MAP3 = 4'd9;
  localparam logic [3:0] S_MRD  = 4'd10;
  localparam logic [3:0] S_UPD  = 4'd11;
  localparam logic [3:0] S_RD   = 4'd12;
  localparam logic [3:0] S_RDW  = 4'd13;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cord_t;

  function automatic cord_t cord_init(input logic signed [ANG_W-1:0] xi,
                                      input logic signed [ANG_W-1:0] yi);
    cord_t c;
    c.x = xi;
    c.y = yi;
    c.z = '0;
    if (xi < 0) begin
      c.z = (yi >= 0) ? (ANG_W'(64'sd1 <<< 31)) : -(ANG_W'(64'sd1 <<< 31));
      c.x = -xi;
      c.y = -yi;
    end
    return c;
  endfunction

  function automatic cord_t cord_step(input cord_t c, input logic [4:0] i);
    cord_t                   n;
    logic signed [ANG_W-1:0] a;
    a = $signed({2'b00, atan_turn(i)});
    if (c.y > 0) begin
      n.x = c.x + (c.y >>> i);
      n.y = c.y - (c.x >>> i);
      n.z = c.z + a;
    end else begin
      n.x = c.x - (c.y >>> i);
      n.y = c.y + (c.x >>> i);
      n.z = c.z - a;
    end
    return n;
  endfunction

  logic [3:0]      state_r;
  logic [AW-1:0]   clr_cnt_r;
  lrip_item_t      item_r;
  logic [38:0]     xx_r, yy_r, zz_r;
  logic [39:0]     radh_r, radr_r;
  logic [21:0]     remh_r, remr_r;
  logic [19:0]     rooth_r, rootr_r;
  logic [4:0]      cnt_r;
  cord_t           cp_r, cy_r;
  logic            pzero_r, yzero_r;
  logic signed [45:0] rt_r;
  logic signed [34:0] colnum_r;
  logic signed [55:0] rowprod_r;
  logic [47:0]     colprod_r;
  logic [RW-1:0]   row_r;
  logic [CLW-1:0]  col_r;
  logic [AW-1:0]   addr_r;
  logic [19:0]     rdata_r;
  logic [19:0]     mem [DEPTH];

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [5:0]      out_row_r;
  logic [9:0]      out_col_r;
  logic [19:0]     out_val_r;

  logic [RCW-1:0]  rows_c;
  logic [CCW-1:0]  cols_c;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [19:0]     mem_wdata;

  logic [21:0]     remh_sh, remr_sh, trialh, trialr;
  logic signed [45:0] p46, rt_nxt;
  logic [15:0]     rq, rdiv, cq;
  logic [33:0]     rmul;
  logic [RW-1:0]   row_nxt;
  logic [CLW-1:0]  col_nxt;
  logic [AW-1:0]   pix_addr, rd_addr;

  // clamp image size to the store
  always_comb begin
    if (image_rows == 7'd0) begin
      rows_c = RCW'(1);
    end else if (32'(image_rows) > 32'(MAX_ROWS)) begin
      rows_c = RCW'(MAX_ROWS);
    end else begin
      rows_c = RCW'(image_rows);
    end
    if (image_cols == 11'd0) begin
      cols_c = CCW'(1);
    end else if (32'(image_cols) > 32'(MAX_COLS)) begin
      cols_c = CCW'(MAX_COLS);
    end else begin
      cols_c = CCW'(image_cols);
    end
  end

  // square root digit step
  assign remh_sh = {remh_r[19:0], radh_r[39:38]};
  assign remr_sh = {remr_r[19:0], radr_r[39:38]};
  assign trialh  = {rooth_r, 2'b01};
  assign trialr  = {rootr_r, 2'b01};

  // mapping arithmetic
  always_comb begin
    p46    = 46'(cp_r.z);
    rt_nxt = (46'sd15 <<< 32) - ((p46 <<< 8) + (p46 <<< 6) + (p46 <<< 5) + (p46 <<< 3));
    rq     = (rowprod_r > 0) ? rowprod_r[50:35] : 16'd0;
    rmul   = 34'(rq) * 34'd52429;
    rdiv   = rmul[33:18];
    if (32'(rdiv) > 32'(rows_c) - 32'd1) begin
      row_nxt = RW'(32'(rows_c) - 32'd1);
    end else begin
      row_nxt = RW'(rdiv);
    end
    cq = colprod_r[47:32];
    if (32'(cq) > 32'(cols_c) - 32'd1) begin
      col_nxt = CLW'(32'(cols_c) - 32'd1);
    end else begin
      col_nxt = CLW'(cq);
    end
    pix_addr = AW'(row_r) * AW'(MAX_COLS) + AW'(col_r);
    rd_addr  = AW'(item_r.row) * AW'(MAX_COLS) + AW'(item_r.col);
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_r;
    mem_raddr = pix_addr;
    mem_wdata = '0;
    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      S_MRD: begin
        mem_re = 1'b1;
      end
      S_UPD: begin
        mem_we    = (rdata_r == 20'd0) || (rootr_r < rdata_r);
        mem_wdata = rootr_r;
      end
      S_RD: begin
        mem_re    = (item_r.kind == KIND_READ);
        mem_raddr = rd_addr;
      end
      S_RDW: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (32'(clr_cnt_r) == DEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_not_empty) begin
            item_r  <= q_head;
            state_r <= (q_head.kind == KIND_PROJECT) ? S_SQ : S_RD;
          end
        end
        S_SQ: begin
          xx_r    <= 39'(item_r.x * item_r.x);
          yy_r    <= 39'(item_r.y * item_r.y);
          zz_r    <= 39'(item_r.z * item_r.z);
          state_r <= S_SUM;
        end
        S_SUM: begin
          radh_r  <= 40'(xx_r) + 40'(yy_r);
          radr_r  <= 40'(xx_r) + 40'(yy_r) + 40'(zz_r);
          remh_r  <= '0;
          remr_r  <= '0;
          rooth_r <= '0;
          rootr_r <= '0;
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          radh_r <= {radh_r[37:0], 2'b00};
          radr_r <= {radr_r[37:0], 2'b00};
          if (remh_sh >= trialh) begin
            remh_r  <= remh_sh - trialh;
            rooth_r <= {rooth_r[18:0], 1'b1};
          end else begin
            remh_r  <= remh_sh;
            rooth_r <= {rooth_r[18:0], 1'b0};
          end
          if (remr_sh >= trialr) begin
            remr_r  <= remr_sh - trialr;
            rootr_r <= {rootr_r[18:0], 1'b1};
          end else begin
            remr_r  <= remr_sh;
            rootr_r <= {rootr_r[18:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd19) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          cnt_r   <= '0;
          pzero_r <= (rooth_r == 20'd0) && (item_r.z == 20'sd0);
          yzero_r <= (item_r.x == 20'sd0) && (item_r.y == 20'sd0);
          cp_r    <= cord_init($signed({4'b0000, rooth_r, 10'b0}),
                               ANG_W'(item_r.z) <<< 10);
          cy_r    <= cord_init(ANG_W'(item_r.x) <<< 10, ANG_W'(item_r.y) <<< 10);
          if (rootr_r < min_range) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_NEAR;
            out_row_r    <= '0;
            out_col_r    <= '0;
            out_val_r    <= rootr_r;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          cp_r  <= cord_step(cp_r, cnt_r);
          cy_r  <= cord_step(cy_r, cnt_r);
          cnt_r <= cnt_r + 5'd1;
          if (32'(cnt_r) == CORDIC_STEPS - 1) begin
            state_r <= S_MAP1;
          end
        end
        S_MAP1: begin
          if (pzero_r) begin
            rt_r <= 46'sd15 <<< 32;
          end else begin
            rt_r <= rt_nxt;
          end
          if (yzero_r) begin
            colnum_r <= 35'sd1 <<< 31;
          end else begin
            colnum_r <= 35'(cy_r.z) + (35'sd1 <<< 31);
          end
          state_r <= S_MAP2;
        end
        S_MAP2: begin
          rowprod_r <= 56'(rt_r) * $signed(56'({1'b0, rows_c}));
          if (colnum_r > 0) begin
            colprod_r <= 48'(colnum_r[33:0]) * 48'(cols_c);
          end else begin
            colprod_r <= '0;
          end
          state_r <= S_MAP3;
        end
        S_MAP3: begin
          row_r   <= row_nxt;
          col_r   <= col_nxt;
          state_r <= S_MRD;
        end
        S_MRD: begin
          addr_r  <= pix_addr;
          state_r <= S_UPD;
        end
        S_UPD: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ((rdata_r == 20'd0) || (rootr_r < rdata_r)) ? ST_STORED
                                                                     : ST_FARTHER;
          out_row_r    <= 6'(row_r);
          out_col_r    <= 10'(col_r);
          out_val_r    <= rootr_r;
          state_r      <= S_IDLE;
        end
        S_RD: begin
          addr_r <= rd_addr;
          if (item_r.kind == KIND_READ) begin
            state_r <= S_RDW;
          end else begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_READ;
            out_row_r    <= item_r.row;
            out_col_r    <= item_r.col;
            out_val_r    <= '0;
            state_r      <= S_IDLE;
          end
        end
        S_RDW: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_READ;
          out_row_r    <= item_r.row;
          out_col_r    <= item_r.col;
          out_val_r    <= rdata_r;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign q_pop           = (state_r == S_IDLE) && q_not_empty;
  assign clearing        = (state_r == S_CLR);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_row   = out_row_r;
  assign out_pixel_col   = out_col_r;
  assign out_range_value = out_val_r;

endmodule

@@ rtl/lidar_range_image_projection.sv @@
// ----------------------------------------------------------------------------
// lidar_range_image_projection: LiDAR point to range image projection
// Throughput: one command per engine pass; the square root digit loop and the
// CORDIC iteration loop set the length of the projection pass.
// Reset: a clearing pass writes zero to every store address; busy stays high
// meanwhile. Results are strobed on out_valid for one cycle.
// ----------------------------------------------------------------------------
module lidar_range_image_projection import lrip_pkg::*; #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic signed [19:0] in_point_x,
  input  logic signed [19:0] in_point_y,
  input  logic signed [19:0] in_point_z,
  input  logic [5:0]         in_read_row,
  input  logic [9:0]         in_read_col,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [5:0]         out_pixel_row,
  output logic [9:0]         out_pixel_col,
  output logic [19:0]        out_range_value
);

  logic [6:0]  image_rows_r;
  logic [10:0] image_cols_r;
  logic [19:0] min_range_r;
  logic        take;
  logic        f_push;
  lrip_item_t  f_item;
  lrip_item_t  q_head;
  logic        q_not_empty;
  logic        q_pop;
  logic [2:0]  q_count;
  logic        clearing;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r <= 7'd64;
      image_cols_r <= 11'd1024;
      min_range_r  <= 20'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:      image_rows_r <= cfg_data[6:0];
        CFG_COLS:      image_cols_r <= cfg_data[10:0];
        CFG_MIN_RANGE: min_range_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // hold off transfers while clearing or when the queue may overflow
  assign busy = clearing || ((4'(q_count) + 4'(f_push)) > 4'd2);
  assign take = start && !busy;

  lrip_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .opcode   (in_opcode),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .read_row (in_read_row),
    .read_col (in_read_col),
    .push     (f_push),
    .item     (f_item)
  );

  lrip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  lrip_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .image_rows      (image_rows_r),
    .image_cols      (image_cols_r),
    .min_range       (min_range_r),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_pixel_row   (out_pixel_row),
    .out_pixel_col   (out_pixel_col),
    .out_range_value (out_range_value)
  );

endmodule
